### sv/fsc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and small helpers of the four-sphere chain force block.
// No dependencies; every other file uses it by scoped names.
package fsc_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int NUM_COORDS  = 12;
    localparam int NUM_SLOTS   = 10;
    localparam int CFG_W       = 31;

    // configuration register indexes
    localparam logic [2:0] CFG_IDX_SPACING01 = 3'd0;
    localparam logic [2:0] CFG_IDX_SPACING12 = 3'd1;
    localparam logic [2:0] CFG_IDX_SPACING23 = 3'd2;
    localparam logic [2:0] CFG_IDX_GAIN      = 3'd3;
    localparam logic [2:0] CFG_IDX_CALM      = 3'd4;

    localparam logic [CFG_W-1:0] RST_SPACING = 31'd65536;
    localparam logic [CFG_W-1:0] RST_GAIN    = 31'd65536;
    localparam logic [CFG_W-1:0] RST_CALM    = 31'd655;

    // kinds of result in the emission order
    localparam logic [1:0] KIND_FULL = 2'd0;  // the force itself
    localparam logic [1:0] KIND_NEG  = 2'd1;  // full opposite reaction
    localparam logic [1:0] KIND_HALF = 2'd2;  // halved opposite reaction

    localparam logic [31:0] SMAX = 32'h7fff_ffff;
    localparam logic [31:0] SMIN = 32'h8000_0000;

    typedef struct packed {
        logic [CFG_W-1:0] d0;
        logic [CFG_W-1:0] d1;
        logic [CFG_W-1:0] d2;
        logic [CFG_W-1:0] gain;
        logic [CFG_W-1:0] calm;
    } cfg_t;

    // one finished request: active spheres, saturated forces, centres
    typedef struct packed {
        logic [3:0]                   active;
        logic [NUM_COORDS-1:0][31:0]  frc;
        logic [NUM_COORDS-1:0][31:0]  anc;
    } item_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

    function automatic logic [1:0] slot_src(input logic [3:0] s);
        logic [1:0] r;
        case (s)
            4'd0, 4'd1:       r = 2'd0;
            4'd2, 4'd3, 4'd4: r = 2'd1;
            4'd5, 4'd6, 4'd7: r = 2'd2;
            default:          r = 2'd3;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] slot_dst(input logic [3:0] s);
        logic [1:0] r;
        case (s)
            4'd0, 4'd3: r = 2'd0;
            4'd1, 4'd2, 4'd6: r = 2'd1;
            4'd4, 4'd5, 4'd9: r = 2'd2;
            default:    r = 2'd3;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] slot_kind(input logic [3:0] s);
        logic [1:0] r;
        case (s)
            4'd0, 4'd2, 4'd5, 4'd8: r = KIND_FULL;
            4'd1, 4'd9:             r = KIND_NEG;
            default:                r = KIND_HALF;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] neg_sat(input logic [31:0] f);
        return (f == SMIN) ? SMAX : 32'(-f);
    endfunction

    // -(f/2) with the division truncated toward zero
    function automatic logic [31:0] half_neg(input logic [31:0] f);
        logic [31:0] h;
        h = {f[31], f[31:1]} + {31'd0, f[31] & f[0]};
        return 32'(-h);
    endfunction

endpackage

### sv/four_sphere_chain_restoring_force_top.sv
`timescale 1ns / 1ps
// Top level of the four-sphere chain restoring force block: configuration
// registers, front, queue and back. Uses fsc_pkg, fsc_front, fsc_queue, fsc_back.
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid/s_tready    s_tdata: 12 centre coordinates
//  m_        out        m_tvalid/m_tready    m_tdata, m_tuser (sphere), m_tlast
//  cfg_      in         cfg_wr_en            cfg_addr, cfg_wdata
//
// Processing: a request with a nonzero axis and middle spacing goes through axis
// normalization, a bit-serial square root and nine radix-4 axis-term divisions;
// without an axis it goes straight to the offset evaluation. Each force result
// then leaves at one per cycle from the back while m_tready stays high, and the
// front already works on the next request.
// Reset: synchronous, active low; clears control state and loads register defaults.
// Stalls: m_tready low holds the result register; a full queue holds the front,
// and s_tready drops once one request waits in the input buffer.
module four_sphere_chain_restoring_force_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [2:0]    cfg_addr,
    input  logic [30:0]   cfg_wdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    // first_x, first_y, first_z, second_x .. fourth_z, 32 bits each from bit 0
    input  logic [383:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // force_x, force_y, force_z, anchor_x, anchor_y, anchor_z, 32 bits each
    output logic [191:0]  m_tdata,
    // sphere_index
    output logic [1:0]    m_tuser,
    output logic          m_tlast
);

    fsc_pkg::cfg_t        cfg_reg, cfg_next;
    logic                 push_valid;
    fsc_pkg::item_t       push_item;
    fsc_pkg::item_t       head;
    fsc_pkg::q_status_t   q_status;
    logic                 pop;
    logic                 push;

    // register writes take effect at the next edge; unknown indexes drop
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                fsc_pkg::CFG_IDX_SPACING01: cfg_next.d0   = cfg_wdata;
                fsc_pkg::CFG_IDX_SPACING12: cfg_next.d1   = cfg_wdata;
                fsc_pkg::CFG_IDX_SPACING23: cfg_next.d2   = cfg_wdata;
                fsc_pkg::CFG_IDX_GAIN:      cfg_next.gain = cfg_wdata;
                fsc_pkg::CFG_IDX_CALM:      cfg_next.calm = cfg_wdata;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.d0   <= fsc_pkg::RST_SPACING;
            cfg_reg.d1   <= fsc_pkg::RST_SPACING;
            cfg_reg.d2   <= fsc_pkg::RST_SPACING;
            cfg_reg.gain <= fsc_pkg::RST_GAIN;
            cfg_reg.calm <= fsc_pkg::RST_CALM;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front: buffer one request, build axis terms, evaluate the four offsets
    fsc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (!q_status.full),
        .push_item  (push_item)
    );

    assign push = push_valid && !q_status.full;

    // hold finished requests so front and back stall independently
    fsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .status    (q_status),
        .head      (head)
    );

    // back: advance through the emission slots, one result per cycle while m_tready allows
    fsc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### sv/fsc_front.sv
`timescale 1ns / 1ps
// Front part: takes one request, builds the chain axis, its length and the
// axis terms, then the offsets, tolerance checks and forces. Uses fsc_pkg.
module fsc_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fsc_pkg::cfg_t                       cfg,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fsc_pkg::NUM_COORDS*32-1:0]   s_tdata,
    output logic                                push_valid,
    input  logic                                push_ready,
    output fsc_pkg::item_t                      push_item
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_NORM = 3'd1;
    localparam logic [2:0] ST_SQ   = 3'd2;
    localparam logic [2:0] ST_ROOT = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_EVAL = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic                    in_full_reg, in_full_next;
    logic [11:0][31:0]       in_data_reg, in_data_next;
    logic [2:0]              state_reg, state_next;
    logic [11:0][31:0]       c_reg, c_next;
    logic [2:0]              ax_neg_reg, ax_neg_next;
    logic [2:0][32:0]        am_reg, am_next;
    logic [32:0]             mx_reg, mx_next;
    logic                    axis_on_reg, axis_on_next;
    logic [4:0]              cnt_reg, cnt_next;
    logic [61:0]             acc_reg, acc_next;
    logic [32:0]             rem_reg, rem_next;
    logic [30:0]             root_reg, root_next;
    logic [1:0]              cls_reg, cls_next;
    logic [1:0]              kk_reg, kk_next;
    logic [30:0]             drem_reg, drem_next;
    logic [33:0]             dnum_reg, dnum_next;
    logic [33:0]             q_reg, q_next;
    logic [8:0][32:0]        term_reg, term_next;
    logic [1:0]              ei_reg, ei_next;
    logic [1:0]              ek_reg, ek_next;
    logic                    a_run_reg, a_run_next;
    logic                    b_valid_reg, b_valid_next;
    logic [1:0]              b_i_reg, b_i_next;
    logic [1:0]              b_k_reg, b_k_next;
    logic                    b_big_reg, b_big_next;
    logic                    b_neg_reg, b_neg_next;
    logic [61:0]             b_sq_reg, b_sq_next;
    logic [33:0]             b_hg_reg, b_hg_next;
    logic [62:0]             b_lg_reg, b_lg_next;
    logic [63:0]             sum_reg, sum_next;
    logic                    big_reg, big_next;
    logic [3:0]              active_reg, active_next;
    logic [11:0][31:0]       frc_reg, frc_next;

    // load-time axis
    logic [2:0][32:0]        ld_ax;
    logic [2:0][32:0]        ld_am;
    logic [32:0]             ld_mx;
    logic                    ld_axis_on;

    // stage A of the offset evaluation
    logic [3:0]              a_j;
    logic [1:0]              a_cls;
    logic [3:0]              a_tidx;
    logic [35:0]             a_base, a_term, a_dbl;
    logic [34:0]             a_m;
    logic                    a_tneg;

    // stage B
    logic [63:0]             lim;
    logic [63:0]             b_total;
    logic [64:0]             b_rnd, b_res;
    logic                    b_res_big;
    logic [31:0]             b_f;
    logic [3:0]              b_j;

    assign s_tready = !in_full_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ld_ax[k] = {in_data_reg[6+k][31], in_data_reg[6+k]}
                     - {in_data_reg[3+k][31], in_data_reg[3+k]};
            ld_am[k] = ld_ax[k][32] ? 33'(-ld_ax[k]) : ld_ax[k];
        end
        ld_mx = ld_am[0];
        if (ld_am[1] > ld_mx) ld_mx = ld_am[1];
        if (ld_am[2] > ld_mx) ld_mx = ld_am[2];
        ld_axis_on = (ld_mx != 33'd0) && (cfg.d1 != '0);
    end

    always_comb begin
        a_j    = 4'({ei_reg, 1'b0}) + 4'(ei_reg) + 4'(ek_reg);
        a_cls  = (ei_reg == 2'd0) ? 2'd0 : ((ei_reg == 2'd3) ? 2'd2 : 2'd1);
        a_tidx = 4'({a_cls, 1'b0}) + 4'(a_cls) + 4'(ek_reg);
        a_base = {{4{c_reg[3+ek_reg][31]}}, c_reg[3+ek_reg]}
               + {{4{c_reg[6+ek_reg][31]}}, c_reg[6+ek_reg]}
               - {{3{c_reg[a_j][31]}}, c_reg[a_j], 1'b0};
        // expected places before the middle pair point backward along the axis
        a_tneg = ax_neg_reg[ek_reg] ^ !ei_reg[1];
        if (!axis_on_reg)
            a_term = '0;
        else if (a_tneg)
            a_term = 36'(-{3'd0, term_reg[a_tidx]});
        else
            a_term = {3'd0, term_reg[a_tidx]};
        a_dbl = a_base + a_term;
        a_m   = a_dbl[35] ? 35'(-a_dbl) : a_dbl[34:0];
    end

    always_comb begin
        lim       = 64'(cfg.calm) << (fsc_pkg::FRAC_BITS + 2);
        b_total   = 64'({b_hg_reg[30:0], 32'd0}) + 64'(b_lg_reg);
        b_rnd     = 65'(b_total) + (65'd1 << fsc_pkg::FRAC_BITS);
        b_res     = b_rnd >> (fsc_pkg::FRAC_BITS + 1);
        b_res_big = (b_hg_reg[33:31] != 3'd0) || (b_res[64:31] != '0);
        if (b_neg_reg)
            b_f = b_res_big ? fsc_pkg::SMIN : 32'(-{1'b0, b_res[30:0]});
        else
            b_f = b_res_big ? fsc_pkg::SMAX : {1'b0, b_res[30:0]};
        b_j = 4'({b_i_reg, 1'b0}) + 4'(b_i_reg) + 4'(b_k_reg);
    end

    always_comb begin
        logic [33:0] rt_rem2;
        logic [32:0] rt_trial;
        logic [62:0] mul_s;
        logic [62:0] mul_p;
        logic [31:0] dv_r;
        logic [30:0] dv_rem;
        logic [33:0] dv_num;
        logic [33:0] dv_q;
        logic [3:0]  t_idx;

        in_full_next = in_full_reg;
        in_data_next = in_data_reg;
        state_next   = state_reg;
        c_next       = c_reg;
        ax_neg_next  = ax_neg_reg;
        am_next      = am_reg;
        mx_next      = mx_reg;
        axis_on_next = axis_on_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        cls_next     = cls_reg;
        kk_next      = kk_reg;
        drem_next    = drem_reg;
        dnum_next    = dnum_reg;
        q_next       = q_reg;
        term_next    = term_reg;
        ei_next      = ei_reg;
        ek_next      = ek_reg;
        a_run_next   = a_run_reg;
        sum_next     = sum_reg;
        big_next     = big_reg;
        active_next  = active_reg;
        frc_next     = frc_reg;

        b_valid_next = (state_reg == ST_EVAL) && a_run_reg;
        b_i_next     = ei_reg;
        b_k_next     = ek_reg;
        b_neg_next   = a_dbl[35];
        b_big_next   = (a_m[34:31] != 4'd0);
        b_sq_next    = 62'(a_m[30:0]) * 62'(a_m[30:0]);
        b_hg_next    = 34'(a_m[34:32]) * 34'(cfg.gain);
        b_lg_next    = 63'(a_m[31:0]) * 63'(cfg.gain);

        rt_rem2  = {rem_reg[31:0], acc_reg[61:60]};
        rt_trial = {root_reg, 2'b01};
        mul_s    = '0;
        case (cls_reg)
            2'd0:    mul_s = 63'({cfg.d0, 1'b0}) + 63'(cfg.d1);
            2'd1:    mul_s = 63'(cfg.d1);
            default: mul_s = 63'({cfg.d2, 1'b0}) + 63'(cfg.d1);
        endcase
        mul_p = mul_s * 63'(am_reg[kk_reg][29:0]) + 63'(root_reg[30:1]);
        dv_rem = drem_reg;
        dv_num = dnum_reg;
        dv_q   = q_reg;
        dv_r   = '0;
        for (int st = 0; st < 2; st++) begin
            dv_r = {dv_rem, dv_num[33]};
            dv_num = {dv_num[32:0], 1'b0};
            if (dv_r >= 32'(root_reg)) begin
                dv_r = dv_r - 32'(root_reg);
                dv_q = {dv_q[32:0], 1'b1};
            end else begin
                dv_q = {dv_q[32:0], 1'b0};
            end
            dv_rem = dv_r[30:0];
        end
        t_idx = 4'({cls_reg, 1'b0}) + 4'(cls_reg) + 4'(kk_reg);

        if (s_tvalid && !in_full_reg) begin
            in_full_next = 1'b1;
            in_data_next = s_tdata;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_full_reg) begin
                    in_full_next = 1'b0;
                    c_next       = in_data_reg;
                    for (int k = 0; k < 3; k++) ax_neg_next[k] = ld_ax[k][32];
                    am_next      = ld_am;
                    mx_next      = ld_mx;
                    axis_on_next = ld_axis_on;
                    ei_next      = 2'd0;
                    ek_next      = 2'd0;
                    a_run_next   = 1'b1;
                    state_next   = ld_axis_on ? ST_NORM : ST_EVAL;
                end
            end
            ST_NORM: begin
                // bring the largest magnitude into [2^29, 2^30)
                if (mx_reg[32:30] != 3'd0) begin
                    mx_next = mx_reg >> 1;
                    for (int k = 0; k < 3; k++) am_next[k] = am_reg[k] >> 1;
                end else if (!mx_reg[29]) begin
                    mx_next = mx_reg << 1;
                    for (int k = 0; k < 3; k++) am_next[k] = am_reg[k] << 1;
                end else begin
                    cnt_next   = '0;
                    acc_next   = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                acc_next = acc_reg + 62'(am_reg[cnt_reg[1:0]][29:0])
                                   * 62'(am_reg[cnt_reg[1:0]][29:0]);
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd2) begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    root_next  = '0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (rt_rem2 >= 34'(rt_trial)) begin
                    rem_next  = 33'(rt_rem2 - 34'(rt_trial));
                    root_next = {root_reg[29:0], 1'b1};
                end else begin
                    rem_next  = rt_rem2[32:0];
                    root_next = {root_reg[29:0], 1'b0};
                end
                acc_next = {acc_reg[59:0], 2'b00};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd30) begin
                    cls_next   = 2'd0;
                    kk_next    = 2'd0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                drem_next  = 31'(mul_p[62:34]);
                dnum_next  = mul_p[33:0];
                q_next     = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                drem_next = dv_rem;
                dnum_next = dv_num;
                q_next    = dv_q;
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == 5'd16) begin
                    term_next[t_idx] = dv_q[32:0];
                    if (kk_reg == 2'd2) begin
                        kk_next = 2'd0;
                        cls_next = cls_reg + 2'd1;
                    end else begin
                        kk_next = kk_reg + 2'd1;
                    end
                    if (kk_reg == 2'd2 && cls_reg == 2'd2) begin
                        ei_next    = 2'd0;
                        ek_next    = 2'd0;
                        a_run_next = 1'b1;
                        state_next = ST_EVAL;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_EVAL: begin
                if (a_run_reg) begin
                    if (ek_reg == 2'd2) begin
                        ek_next = 2'd0;
                        if (ei_reg == 2'd3) a_run_next = 1'b0;
                        else                ei_next = ei_reg + 2'd1;
                    end else begin
                        ek_next = ek_reg + 2'd1;
                    end
                end
                if (b_valid_reg) begin
                    sum_next = ((b_k_reg == 2'd0) ? 64'd0 : sum_reg) + 64'(b_sq_reg);
                    big_next = ((b_k_reg == 2'd0) ? 1'b0 : big_reg) | b_big_reg;
                    frc_next[b_j] = b_f;
                    if (b_k_reg == 2'd2) begin
                        active_next[b_i_reg] = big_next || (sum_next > lim);
                        if (b_i_reg == 2'd3) state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                // drop a request that produced no force
                if (active_reg == 4'd0 || push_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign push_valid       = (state_reg == ST_DONE) && (active_reg != 4'd0);
    assign push_item.active = active_reg;
    assign push_item.frc    = frc_reg;
    assign push_item.anc    = c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_full_reg <= 1'b0;
            state_reg   <= ST_IDLE;
            a_run_reg   <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            in_full_reg <= in_full_next;
            state_reg   <= state_next;
            a_run_reg   <= a_run_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_data_reg <= in_data_next;
        c_reg       <= c_next;
        ax_neg_reg  <= ax_neg_next;
        am_reg      <= am_next;
        mx_reg      <= mx_next;
        axis_on_reg <= axis_on_next;
        cnt_reg     <= cnt_next;
        acc_reg     <= acc_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        cls_reg     <= cls_next;
        kk_reg      <= kk_next;
        drem_reg    <= drem_next;
        dnum_reg    <= dnum_next;
        q_reg       <= q_next;
        term_reg    <= term_next;
        ei_reg      <= ei_next;
        ek_reg      <= ek_next;
        b_i_reg     <= b_i_next;
        b_k_reg     <= b_k_next;
        b_big_reg   <= b_big_next;
        b_neg_reg   <= b_neg_next;
        b_sq_reg    <= b_sq_next;
        b_hg_reg    <= b_hg_next;
        b_lg_reg    <= b_lg_next;
        sum_reg     <= sum_next;
        big_reg     <= big_next;
        active_reg  <= active_next;
        frc_reg     <= frc_next;
    end

endmodule

### sv/fsc_queue.sv
`timescale 1ns / 1ps
// Short queue of finished requests between front and back.
// Uses fsc_pkg::item_t and fsc_pkg::q_status_t.
module fsc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  fsc_pkg::item_t       push_item,
    input  logic                 pop,
    output fsc_pkg::q_status_t   status,
    output fsc_pkg::item_t       head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fsc_pkg::item_t        mem_reg [DEPTH];
    logic [PW-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]         count_reg, count_next;

    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == CW'(DEPTH));
    assign head         = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)  rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)      count_next = count_reg + CW'(1);
        else if (pop && !push) count_next = count_reg - CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_item;
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!status.full || pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> status.valid)
        else $error("queue read while empty");
`endif

endmodule

### sv/fsc_back.sv
`timescale 1ns / 1ps
// Back part: walks the emission slots of the head request and drives the
// result register. Uses fsc_pkg slot tables and reaction helpers.
module fsc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fsc_pkg::q_status_t   q_status,
    input  fsc_pkg::item_t       head,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [191:0]         m_tdata,
    output logic [1:0]           m_tuser,
    output logic                 m_tlast
);

    logic [3:0]        slot_reg, slot_next;
    logic              valid_reg, valid_next;
    logic [191:0]      data_reg, data_next;
    logic [1:0]        user_reg, user_next;
    logic              last_reg, last_next;

    logic [fsc_pkg::NUM_SLOTS-1:0] en;
    logic [3:0]        cur;
    logic              later;
    logic              adv;
    logic [1:0]        src, dst, kind;
    logic [3:0]        sbase, dbase;
    logic [2:0][31:0]  fsel;

    always_comb begin
        for (int s = 0; s < fsc_pkg::NUM_SLOTS; s++)
            en[s] = head.active[fsc_pkg::slot_src(4'(s))];
        cur = 4'd0;
        for (int s = fsc_pkg::NUM_SLOTS - 1; s >= 0; s--)
            if (en[s] && 4'(s) >= slot_reg) cur = 4'(s);
        later = 1'b0;
        for (int s = 0; s < fsc_pkg::NUM_SLOTS; s++)
            if (en[s] && 4'(s) > cur) later = 1'b1;
        src   = fsc_pkg::slot_src(cur);
        dst   = fsc_pkg::slot_dst(cur);
        kind  = fsc_pkg::slot_kind(cur);
        sbase = 4'({src, 1'b0}) + 4'(src);
        dbase = 4'({dst, 1'b0}) + 4'(dst);
        for (int k = 0; k < 3; k++) begin
            case (kind)
                fsc_pkg::KIND_FULL: fsel[k] = head.frc[sbase + 4'(k)];
                fsc_pkg::KIND_NEG:  fsel[k] = fsc_pkg::neg_sat(head.frc[sbase + 4'(k)]);
                default:            fsel[k] = fsc_pkg::half_neg(head.frc[sbase + 4'(k)]);
            endcase
        end
    end

    assign adv = q_status.valid && (!valid_reg || m_tready);
    assign pop = adv && !later;

    always_comb begin
        slot_next  = slot_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        if (adv) begin
            valid_next = 1'b1;
            data_next  = {head.anc[dbase + 4'd2], head.anc[dbase + 4'd1], head.anc[dbase],
                          fsel[2], fsel[1], fsel[0]};
            user_next  = dst;
            last_next  = !later;
            slot_next  = later ? cur + 4'd1 : 4'd0;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg  <= 4'd0;
            valid_reg <= 1'b0;
        end else begin
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

`ifndef NO_ASSERTIONS
    a_rise_from_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(q_status.valid))
        else $error("result shown without a queued request");
    a_pop_shows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (m_tvalid && m_tlast))
        else $error("request retired without its last result");
    a_mid_request_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (slot_reg != 4'd0) |-> q_status.valid)
        else $error("slot walk running with no request at the head");
`endif

endmodule

### tb/four_sphere_chain_restoring_force_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of four_sphere_chain_restoring_force_top: drives centre
// requests with random gaps, predicts every force result and checks the result stream.
// Depends on fsc_pkg and the block's RTL only.
module four_sphere_chain_restoring_force_top_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    // two requests may still be in flight
    localparam int SETTLE_CYCLES  = 600;
    localparam int LONG_HOLD      = 600;
    localparam int MAX_PRINTS     = 60;
    localparam logic [2:0] UNUSED_REG_IDX = 3'd7;
    localparam longint S_MAX = 64'sd2147483647;
    localparam longint S_MIN = -64'sd2147483648;

    // one predicted force result
    typedef struct packed {
        logic [1:0]       sphere;
        logic [5:0][31:0] fld;     // force x,y,z then anchor x,y,z
        logic             last;
    } force_rec_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [2:0]   cfg_addr;
    logic [30:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [383:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    four_sphere_chain_restoring_force_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    // register copies used by the predictor
    bit [30:0] spc01 = fsc_pkg::RST_SPACING;
    bit [30:0] spc12 = fsc_pkg::RST_SPACING;
    bit [30:0] spc23 = fsc_pkg::RST_SPACING;
    bit [30:0] gain  = fsc_pkg::RST_GAIN;
    bit [30:0] calm  = fsc_pkg::RST_CALM;

    logic [383:0] pending_centres[$];
    force_rec_t   expected_forces[$];
    int  mismatches = 0;
    int  quiet_cycles = 0;
    bit  offering = 0;
    bit  in_taken = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_left = 0;
    bit  hold_req = 0;
    bit  steady_in = 0;
    bit  steady_out = 0;

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    function automatic bit [63:0] magnitude(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [383:0] pack_centres(input int v[12]);
        logic [383:0] d;
        for (int i = 0; i < 12; i++) d[i*32 +: 32] = v[i];
        return d;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    endtask

    // Expected places lie on the axis c1->c2 around the midpoint; offsets beyond the
    // calm radius become forces, with reactions pushed to the neighbours.
    function automatic void predict_forces(input logic [383:0] d);
        longint c[4][3];
        longint ax[3];
        longint dbl[3];
        longint f[4][3];
        longint r[3];
        longint term;
        bit [63:0] am[3];
        bit [63:0] s[4];
        bit [63:0] mx, len, n, bitv, t, m, hg, total, res, sum, lim;
        bit act[4];
        bit axis_on;
        force_rec_t recs[$];
        force_rec_t rec;
        for (int i = 0; i < 4; i++)
            for (int k = 0; k < 3; k++)
                c[i][k] = longint'($signed(d[(i*3+k)*32 +: 32]));
        mx = 0;
        for (int k = 0; k < 3; k++) begin
            ax[k] = c[2][k] - c[1][k];
            am[k] = magnitude(ax[k]);
            if (am[k] > mx) mx = am[k];
        end
        axis_on = (mx != 0) && (spc12 != 0);
        len = 0;
        if (axis_on) begin
            // normalize so the largest axis magnitude sits in [2^29, 2^30)
            while (mx >= (64'd1 << 30)) begin
                mx >>= 1;
                for (int k = 0; k < 3; k++) am[k] >>= 1;
            end
            while (mx < (64'd1 << 29)) begin
                mx <<= 1;
                for (int k = 0; k < 3; k++) am[k] <<= 1;
            end
            n = am[0]*am[0] + am[1]*am[1] + am[2]*am[2];
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0) begin
                if (n >= len + bitv) begin
                    n = n - (len + bitv);
                    len = (len >> 1) + bitv;
                end else begin
                    len >>= 1;
                end
                bitv >>= 2;
            end
            if (len == 0) axis_on = 0;
        end
        s[0] = 2 * 64'(spc01) + 64'(spc12);
        s[1] = 64'(spc12);
        s[2] = 64'(spc12);
        s[3] = 2 * 64'(spc23) + 64'(spc12);
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 3; k++) begin
                term = 0;
                if (axis_on) begin
                    t = (s[i] * am[k] + (len >> 1)) / len;
                    term = ax[k] < 0 ? -longint'(t) : longint'(t);
                    if (i < 2) term = -term;
                end
                dbl[k] = c[1][k] + c[2][k] - 2 * c[i][k] + term;
            end
            // exact squared-length test on the doubled offset
            act[i] = 0;
            sum = 0;
            for (int k = 0; k < 3; k++) begin
                m = magnitude(dbl[k]);
                if (m >= (64'd1 << 31)) act[i] = 1;
                sum += m * m;
            end
            lim = (64'(calm) * 4) << fsc_pkg::FRAC_BITS;
            if (sum > lim) act[i] = 1;
            for (int k = 0; k < 3; k++) begin
                f[i][k] = 0;
                if (act[i]) begin
                    m = magnitude(dbl[k]);
                    hg = (m >> 32) * 64'(gain);
                    if (hg >= (64'd1 << 31)) begin
                        res = 64'd1 << 40;
                    end else begin
                        total = (hg << 32) + (m & 64'hFFFF_FFFF) * 64'(gain);
                        res = (total + (64'd1 << fsc_pkg::FRAC_BITS))
                            >> (fsc_pkg::FRAC_BITS + 1);
                    end
                    if (dbl[k] < 0)
                        f[i][k] = res >= (64'd1 << 31) ? S_MIN : -longint'(res);
                    else
                        f[i][k] = res > 64'(S_MAX) ? S_MAX : longint'(res);
                end
            end
        end
        for (int i = 0; i < 4; i++) begin
            if (!act[i]) continue;
            // full reactions at the chain ends, halved ones from the middle spheres
            for (int k = 0; k < 3; k++)
                if (i == 0 || i == 3) r[k] = f[i][k] == S_MIN ? S_MAX : -f[i][k];
                else r[k] = -(f[i][k] / 2);
            for (int e = 0; e < 3; e++) begin
                if (e == 0) rec.sphere = 2'(i);
                else if (i == 0) rec.sphere = 2'd1;
                else if (i == 3) rec.sphere = 2'd2;
                else rec.sphere = e == 1 ? 2'(i - 1) : 2'(i + 1);
                if (e == 2 && (i == 0 || i == 3)) break;
                for (int k = 0; k < 3; k++) begin
                    rec.fld[k]     = e == 0 ? f[i][k][31:0] : r[k][31:0];
                    rec.fld[3 + k] = c[rec.sphere][k][31:0];
                end
                rec.last = 0;
                recs.push_back(rec);
            end
        end
        if (recs.size() > 0) recs[recs.size() - 1].last = 1;
        foreach (recs[j]) expected_forces.push_back(recs[j]);
    endfunction

    // acceptance, prediction, checking and the watchdog, all sampled at the rising edge
    always @(posedge aclk) begin
        force_rec_t want;
        string names[6];
        names = '{"force_x", "force_y", "force_z", "anchor_x", "anchor_y", "anchor_z"};
        if (aresetn) begin
            quiet_cycles++;
            if (s_tvalid && s_tready) begin
                predict_forces(s_tdata);
                in_taken = 1;
                quiet_cycles = 0;
            end
            if (m_tvalid && m_tready) begin
                quiet_cycles = 0;
                if (expected_forces.size() == 0) begin
                    report("unexpected result, sphere", 32'(m_tuser), 32'd0);
                end else begin
                    want = expected_forces.pop_front();
                    if (m_tuser !== want.sphere)
                        report("sphere_index", 32'(m_tuser), 32'(want.sphere));
                    for (int k = 0; k < 6; k++)
                        if (m_tdata[k*32 +: 32] !== want.fld[k])
                            report(names[k], m_tdata[k*32 +: 32], want.fld[k]);
                    if (m_tlast !== want.last)
                        report("last", 32'(m_tlast), 32'(want.last));
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired, %0d results outstanding", expected_forces.size());
                $display("four_sphere_chain_restoring_force_top_tb: FAIL");
                $finish;
            end
        end
    end

    // request driver: drop valid after acceptance, idle a random gap, offer the next
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_taken) begin
                in_taken = 0;
                offering = 0;
                send_gap = pick_gap(steady_in);
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_centres.size() > 0) begin
                    s_tdata <= pending_centres.pop_front();
                    offering = 1;
                end
            end
            s_tvalid <= offering;
        end
    end

    // result receiver: random stalls, plus one long hold-off on request
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_req) begin
                hold_req = 0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                recv_gap = pick_gap(steady_out);
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input bit [30:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            fsc_pkg::CFG_IDX_SPACING01: spc01 = val;
            fsc_pkg::CFG_IDX_SPACING12: spc12 = val;
            fsc_pkg::CFG_IDX_SPACING23: spc23 = val;
            fsc_pkg::CFG_IDX_GAIN:      gain  = val;
            fsc_pkg::CFG_IDX_CALM:      calm  = val;
            default: ;
        endcase
    endtask

    task automatic set_chain(input bit [30:0] d0, input bit [30:0] d1, input bit [30:0] d2,
                             input bit [30:0] g, input bit [30:0] cl);
        write_reg(fsc_pkg::CFG_IDX_SPACING01, d0);
        write_reg(fsc_pkg::CFG_IDX_SPACING12, d1);
        write_reg(fsc_pkg::CFG_IDX_SPACING23, d2);
        write_reg(fsc_pkg::CFG_IDX_GAIN, g);
        write_reg(fsc_pkg::CFG_IDX_CALM, cl);
        // an index past the register file must be ignored
        write_reg(UNUSED_REG_IDX, 31'($urandom));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // hold until every request is out and every result back, then let the block drain
    task automatic wait_idle();
        wait (pending_centres.size() == 0 && !offering && expected_forces.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // half of them chains laid along an axis near their expected places, the rest noise
    task automatic queue_random(input int count);
        int v[12];
        int sel, dir_axis, noise;
        longint sgn, base, p[4];
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 50) begin
                dir_axis = $urandom_range(0, 2);
                sgn = $urandom_range(0, 1) ? 1 : -1;
                p[1] = -longint'(spc12 / 2);
                p[2] = longint'(spc12) + p[1];
                p[0] = p[1] - longint'(spc01);
                p[3] = p[2] + longint'(spc23);
                for (int k = 0; k < 3; k++) begin
                    base = longint'($urandom_range(0, 32'h01FF_FFFF)) - 64'sh0100_0000;
                    for (int i = 0; i < 4; i++) begin
                        noise = $urandom_range(0, 99) < 40 ? 0
                              : int'($urandom_range(0, 2048)) - 1024;
                        v[i*3 + k] = int'(base + (k == dir_axis ? sgn * p[i] : 0) + noise);
                    end
                end
            end else if (sel < 80) begin
                foreach (v[j]) v[j] = $urandom;
            end else begin
                foreach (v[j]) v[j] = int'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
            end
            pending_centres.push_back(pack_centres(v));
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed requests under reset settings, no idling
        steady_in  = 1;
        steady_out = 1;
        pending_centres.push_back(pack_centres('{0, 0, 0, 65536, 0, 0,
                                                 131072, 0, 0, 196608, 0, 0}));
        pending_centres.push_back(pack_centres('{0, 0, 196608, 0, 0, 131072,
                                                 0, 0, 65536, 0, 0, 0}));
        pending_centres.push_back(pack_centres('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}));
        pending_centres.push_back(pack_centres('{12{32'h7FFF_FFFF}}));
        pending_centres.push_back(pack_centres('{12{32'h8000_0000}}));
        pending_centres.push_back(pack_centres('{32'h7FFF_FFFF, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h8000_0000}));
        // coincident middle centres: zero axis with forces on the ends
        pending_centres.push_back(pack_centres('{-300000, 5, 7, 0, 0, 0,
                                                 0, 0, 0, 400000, -9, 2}));
        // only the last sphere pushed sideways by half a unit
        pending_centres.push_back(pack_centres('{0, 0, 0, 65536, 0, 0,
                                                 131072, 0, 0, 196608, 32768, 0}));
        // first sphere off by just under the calm radius
        pending_centres.push_back(pack_centres('{0, 6000, 0, 65536, 0, 0,
                                                 131072, 0, 0, 196608, 0, 0}));
        pending_centres.push_back(pack_centres('{0, 0, 0, 65536, 65536, 0,
                                                 131072, 0, 0, 196608, 0, 0}));
        pending_centres.push_back(pack_centres('{32'h7FFF_FFFF, 0, 0, 0, 0, 0,
                                                 0, 1, 0, 32'h8000_0000, 0, 0}));
        queue_random(6);
        wait_idle();

        // scaled chain; the receiver stalls long while requests keep coming
        steady_in  = 0;
        steady_out = 0;
        set_chain(31'd196608, 31'd196608, 31'd196608, 31'd65536, 31'd655);
        queue_random(60);
        hold_req = 1;
        wait_idle();

        // zero middle spacing, largest gain, no calm radius
        set_chain(31'd65536, 31'd0, 31'd131072, 31'h7FFF_FFFF, 31'd0);
        queue_random(35);
        wait_idle();

        // every register at its maximum
        steady_out = 1;
        set_chain(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                  31'h7FFF_FFFF);
        queue_random(35);
        wait_idle();

        // zero gain: forces exist but are all zero
        steady_out = 0;
        set_chain(31'd1, 31'd2, 31'd0, 31'd0, 31'd0);
        queue_random(30);
        wait_idle();

        // random spacings, moderate gain and radius
        steady_in = 1;
        set_chain(31'($urandom_range(0, 32'h0008_0000)), 31'($urandom_range(1, 32'h0008_0000)),
                  31'($urandom_range(0, 32'h0008_0000)), 31'd16384, 31'h1000);
        queue_random(40);
        wait_idle();
        steady_in = 0;
        queue_random(40);
        wait_idle();

        if (mismatches == 0) begin
            $display("four_sphere_chain_restoring_force_top_tb: PASS");
        end else begin
            $display("four_sphere_chain_restoring_force_top_tb: FAIL");
        end
        $finish;
    end

endmodule

### four_sphere_chain_restoring_force_top.f
sv/fsc_pkg.sv
sv/fsc_front.sv
sv/fsc_queue.sv
sv/fsc_back.sv
sv/four_sphere_chain_restoring_force_top.sv
tb/four_sphere_chain_restoring_force_top_tb.sv
